// ===== rtl/swc_pkg.sv =====
// swc_pkg: shared constants, register codes and controller/datapath structs
// for the star window centroid block; no dependencies
`default_nettype none

package swc_pkg;

  // field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned GraySumW = 13;
  localparam int unsigned DimW     = 9;
  localparam int unsigned CountW   = 8;
  localparam int unsigned OrgW     = 12;
  localparam int unsigned WsumW    = 24;
  localparam int unsigned AxisSumW = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned MaxDim   = 256;
  localparam int unsigned CenterW  = 21;
  localparam int unsigned EdgeW    = 22;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 12;

  // quotient bits: centroid below MaxDim pixels, FracBits fraction bits
  localparam int unsigned QuotW    = 16;
  localparam int unsigned StepCntW = 4;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(QuotW - 1);

  // subsample offset of 0.45 pixel in fixed point
  localparam logic [CenterW-1:0] SubOffset = CenterW'((45 << FracBits) / 100);

  // configuration register codes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_WIDTH  = 4'd0,
    REG_WINDOW_HEIGHT = 4'd1,
    REG_ORIGIN_X      = 4'd2,
    REG_ORIGIN_Y      = 4'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] window_width;
    logic [DimW-1:0] window_height;
    logic [OrgW-1:0] origin_x;
    logic [OrgW-1:0] origin_y;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // restart the window
    logic accum;      // take one pixel
    logic start_div;  // load dividers with the closing sums
    logic div_step;   // one quotient bit per axis
    logic load_out;   // format result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_pixel; // pixel at the input closes the window
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/star_window_centroid.sv =====
// star_window_centroid: intensity weighted centroid of a tracking window
// after the last pixel word is accepted: 16 restoring divide steps, one quotient
//   bit per cycle, then the result word load once the output register is free
// one pixel per cycle inside a window; intake stays closed until the result loads
// reset (rst_ni, async low): 16x16 window at origin 0, sums and counts cleared
// depends on swc_pkg, swc_ctrl, swc_datapath
`default_nettype none

module star_window_centroid (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // center_x [20:0], center_y [41:21],
                                           // left_x [63:42], top_y [85:64], zero pad
  output logic             m_axis_tuser,   // found
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [swc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [swc_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers, writable at any time, taken every cycle
  swc_pkg::cfg_t cfg_q;
  logic          cfg_write;
  logic          cfg_hit;

  assign cfg_ready_o = 1'b1;

  // a write to an index beyond the register list is dropped and does not
  // restart the window
  always_comb begin
    case (cfg_index_i)
      swc_pkg::REG_WINDOW_WIDTH,
      swc_pkg::REG_WINDOW_HEIGHT,
      swc_pkg::REG_ORIGIN_X,
      swc_pkg::REG_ORIGIN_Y: cfg_hit = 1'b1;
      default:               cfg_hit = 1'b0;
    endcase
  end

  assign cfg_write = cfg_valid_i & cfg_ready_o & cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_width  <= swc_pkg::DimW'(16);
      cfg_q.window_height <= swc_pkg::DimW'(16);
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        swc_pkg::REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data_i[swc_pkg::DimW-1:0];
        swc_pkg::REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data_i[swc_pkg::DimW-1:0];
        swc_pkg::REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data_i;
        swc_pkg::REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // controller / datapath handshake
  swc_pkg::cmd_t    cmd;
  swc_pkg::status_t status;

  swc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_write_i (cfg_write),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  logic [swc_pkg::CenterW-1:0] center_x, center_y;
  logic [swc_pkg::EdgeW-1:0]   left_x, top_y;

  // datapath: gray conversion, weighted sums, dividers and the output word
  swc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .center_x_o  (center_x),
    .center_y_o  (center_y),
    .left_x_o    (left_x),
    .top_y_o     (top_y),
    .found_o     (m_axis_tuser)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata = {2'b00, top_y, left_x, center_y, center_x};

`ifndef SYNTHESIS
  // a result word only appears after the controller loads it
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.load_out))
    else $error("result word appeared without a load");

  // pixel intake stops while the dividers run
  a_no_pixel_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !s_axis_tready)
    else $error("pixel intake open during division");

  // closing a window always hands over to the divider
  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_div |=> !s_axis_tready)
    else $error("window closed but intake still open");

  // the output register is never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/swc_datapath.sv =====
// swc_datapath: pixel accumulators, two restoring dividers and output register
// depends on swc_pkg
`default_nettype none

module swc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swc_pkg::cfg_t                cfg_i,
  input  wire swc_pkg::cmd_t                cmd_i,
  output swc_pkg::status_t                  status_o,
  input  wire logic [swc_pkg::PixW-1:0]     red_i,
  input  wire logic [swc_pkg::PixW-1:0]     green_i,
  input  wire logic [swc_pkg::PixW-1:0]     blue_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [swc_pkg::CenterW-1:0]       center_x_o,
  output logic [swc_pkg::CenterW-1:0]       center_y_o,
  output logic [swc_pkg::EdgeW-1:0]         left_x_o,
  output logic [swc_pkg::EdgeW-1:0]         top_y_o,
  output logic                              found_o
);

  localparam int unsigned DimW  = swc_pkg::DimW;
  localparam int unsigned CntW  = swc_pkg::CountW;
  localparam int unsigned WsW   = swc_pkg::WsumW;
  localparam int unsigned AsW   = swc_pkg::AxisSumW;
  localparam int unsigned QW    = swc_pkg::QuotW;
  localparam int unsigned CW    = swc_pkg::CenterW;
  localparam int unsigned FB    = swc_pkg::FracBits;
  localparam int unsigned ProdW = swc_pkg::PixW + CntW;

  // clamped window size
  logic [DimW-1:0] win_w, win_h;
  always_comb begin
    if (cfg_i.window_width == '0) begin
      win_w = DimW'(1);
    end else if (cfg_i.window_width > DimW'(swc_pkg::MaxDim)) begin
      win_w = DimW'(swc_pkg::MaxDim);
    end else begin
      win_w = cfg_i.window_width;
    end
    if (cfg_i.window_height == '0) begin
      win_h = DimW'(1);
    end else if (cfg_i.window_height > DimW'(swc_pkg::MaxDim)) begin
      win_h = DimW'(swc_pkg::MaxDim);
    end else begin
      win_h = cfg_i.window_height;
    end
  end

  // accumulators
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [WsW-1:0]  wsum_q, wsum_d;
  logic [AsW-1:0]  csum_q, csum_d, rsum_q, rsum_d;
  logic [swc_pkg::GraySumW-1:0] gray_sum;
  logic [swc_pkg::PixW-1:0]     gray;
  logic col_last, row_last;

  assign gray_sum = swc_pkg::GraySumW'(11 * red_i) + swc_pkg::GraySumW'({green_i, 4'b0})
                  + swc_pkg::GraySumW'(5 * blue_i);
  assign gray     = gray_sum[swc_pkg::GraySumW-1:5];

  assign col_last = (({1'b0, col_q} + DimW'(1)) == win_w);
  assign row_last = (({1'b0, row_q} + DimW'(1)) == win_h);

  // full-width products, gray times position
  assign wsum_d = wsum_q + WsW'(gray);
  assign csum_d = csum_q + AsW'(ProdW'(gray) * ProdW'(col_q));
  assign rsum_d = rsum_q + AsW'(ProdW'(gray) * ProdW'(row_q));

  assign status_o.last_pixel = col_last & row_last;
  assign status_o.out_free   = ~out_valid_o | out_ready_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + CntW'(1);
    end else begin
      col_d = col_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      wsum_q <= '0;
      csum_q <= '0;
      rsum_q <= '0;
    end else if (cmd_i.clear) begin
      col_q  <= '0;
      row_q  <= '0;
      wsum_q <= '0;
      csum_q <= '0;
      rsum_q <= '0;
    end else if (cmd_i.accum) begin
      col_q <= col_d;
      row_q <= row_d;
      if (status_o.last_pixel) begin
        wsum_q <= '0;
        csum_q <= '0;
        rsum_q <= '0;
      end else begin
        wsum_q <= wsum_d;
        csum_q <= csum_d;
        rsum_q <= rsum_d;
      end
    end
  end

  // restoring dividers, (sum << FB) / wsum, one bit a cycle per axis
  logic [WsW-1:0] div_q;
  logic           dark_q;
  logic [WsW-1:0] rem_x_q, rem_y_q;
  logic [QW-1:0]  quo_x_q, quo_y_q;
  logic [WsW:0]   trial_x, trial_y;
  logic           ge_x, ge_y;

  assign trial_x = {rem_x_q, quo_x_q[QW-1]};
  assign trial_y = {rem_y_q, quo_y_q[QW-1]};
  assign ge_x    = (trial_x >= {1'b0, div_q});
  assign ge_y    = (trial_y >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      div_q   <= wsum_d;
      dark_q  <= (wsum_d == '0);
      rem_x_q <= csum_d[AsW-1:FB];
      rem_y_q <= rsum_d[AsW-1:FB];
      quo_x_q <= {csum_d[FB-1:0], {(QW-FB){1'b0}}};
      quo_y_q <= {rsum_d[FB-1:0], {(QW-FB){1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_x_q <= ge_x ? WsW'(trial_x - {1'b0, div_q}) : trial_x[WsW-1:0];
      rem_y_q <= ge_y ? WsW'(trial_y - {1'b0, div_q}) : trial_y[WsW-1:0];
      quo_x_q <= {quo_x_q[QW-2:0], ge_x};
      quo_y_q <= {quo_y_q[QW-2:0], ge_y};
    end
  end

  // result formatting
  logic [CW-1:0] base_x, base_y, half_w, half_h, cx, cy;
  assign base_x = CW'({cfg_i.origin_x, {FB{1'b0}}});
  assign base_y = CW'({cfg_i.origin_y, {FB{1'b0}}});
  assign half_w = CW'({win_w, {(FB-1){1'b0}}});
  assign half_h = CW'({win_h, {(FB-1){1'b0}}});
  assign cx = dark_q ? base_x + half_w : base_x + CW'(quo_x_q) + swc_pkg::SubOffset;
  assign cy = dark_q ? base_y + half_h : base_y + CW'(quo_y_q) + swc_pkg::SubOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      center_x_o <= cx;
      center_y_o <= cy;
      left_x_o   <= {1'b0, cx} - {1'b0, half_w};
      top_y_o    <= {1'b0, cy} - {1'b0, half_h};
      found_o    <= ~dark_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swc_ctrl.sv =====
// swc_ctrl: sequencer for pixel intake, division and result hand-off
// depends on swc_pkg
`default_nettype none

module swc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             cfg_write_i,
  input  wire swc_pkg::status_t status_i,
  output swc_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [swc_pkg::StepCntW-1:0] step_q;
  logic accept;

  assign in_ready_o = (state_q == ST_ACCUM);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clear     = cfg_write_i;
    cmd_o.accum     = accept;
    cmd_o.start_div = accept & status_i.last_pixel;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.load_out  = (state_q == ST_OUT) & status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_ACCUM: begin
          step_q <= '0;
          if (cmd_o.start_div) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          step_q <= step_q + swc_pkg::StepCntW'(1);
          if (step_q == swc_pkg::LastStep) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (status_i.out_free) begin
            state_q <= ST_ACCUM;
          end
        end
        default: begin
          state_q <= ST_ACCUM;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
